FILE: hdl/mrr_pkg.sv
// ----------------------------------------------------------------------------
// mrr_pkg
// Types, codes and helper functions shared by the response receiver modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mrr_pkg;

    typedef enum logic [3:0] {
        PH_ADDR    = 4'd0,
        PH_FUNC    = 4'd1,
        PH_COUNT   = 4'd2,
        PH_FIFO_HI = 4'd3,
        PH_FIFO_LO = 4'd4,
        PH_PAYLOAD = 4'd5,
        PH_EXC     = 4'd6,
        PH_CRC_LO  = 4'd7,
        PH_CRC_HI  = 4'd8
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_CRC_BAD   = 3'd1,
        ST_EXCEPTION = 3'd2,
        ST_UNKNOWN   = 3'd3,
        ST_DIAG_BAD  = 3'd4,
        ST_TOO_LONG  = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        FC_COUNT,
        FC_FIXED,
        FC_FIFO,
        FC_EXC,
        FC_UNKNOWN
    } t_fclass;

    localparam logic        ITEM_PAYLOAD = 1'b0;
    localparam logic        ITEM_STATUS  = 1'b1;

    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'hA001;

    localparam logic [7:0]  FN_EXC_MIN   = 8'h80;
    localparam logic [7:0]  FN_DIAG      = 8'h08;
    localparam logic [7:0]  DIAG_ECHO_0  = 8'h54;
    localparam logic [7:0]  DIAG_ECHO_1  = 8'h65;

    localparam logic [2:0]  DIAG_ALL     = 3'b111;

    typedef struct packed {
        logic       item_type;
        logic [7:0] slave_address;
        logic [7:0] function_code;
        logic [7:0] payload_byte;
        logic [7:0] byte_index;
        logic [7:0] payload_length;
        t_status    frame_status;
        logic [7:0] exception_code;
        logic       deliver;
    } t_result;

    // One byte of CRC-16/MODBUS, reflected polynomial, LSB first.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                               input logic [7:0]  b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic t_fclass func_class(input logic [7:0] f);
        t_fclass k;
        if (f >= FN_EXC_MIN) begin
            k = FC_EXC;
        end else begin
            unique case (f)
                8'h01, 8'h02, 8'h03, 8'h04,
                8'h0C, 8'h14, 8'h15, 8'h17: k = FC_COUNT;
                8'h05, 8'h06, 8'h0B, 8'h0F,
                8'h10, 8'h08, 8'h07, 8'h16: k = FC_FIXED;
                8'h18:                      k = FC_FIFO;
                default:                    k = FC_UNKNOWN;
            endcase
        end
        return k;
    endfunction

    // Payload length of the functions with a fixed response size.
    function automatic logic [15:0] fixed_len(input logic [7:0] f);
        logic [15:0] n;
        unique case (f)
            8'h07:   n = 16'd1;
            8'h16:   n = 16'd6;
            default: n = 16'd4;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/mrr_byte_if.sv
// ----------------------------------------------------------------------------
// mrr_byte_if
// Valid/ready channel carrying one received serial byte per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface mrr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

FILE: hdl/mrr_result_if.sv
// ----------------------------------------------------------------------------
// mrr_result_if
// Valid/ready channel carrying one parser result per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface mrr_result_if;
    logic       valid;
    logic       ready;
    logic       item_type;
    logic [7:0] slave_address;
    logic [7:0] function_code;
    logic [7:0] payload_byte;
    logic [7:0] byte_index;
    logic [7:0] payload_length;
    logic [2:0] frame_status;
    logic [7:0] exception_code;
    logic       deliver;

    modport source (output valid, output item_type, output slave_address,
                    output function_code, output payload_byte, output byte_index,
                    output payload_length, output frame_status,
                    output exception_code, output deliver, input ready);
    modport sink   (input valid, input item_type, input slave_address,
                    input function_code, input payload_byte, input byte_index,
                    input payload_length, input frame_status,
                    input exception_code, input deliver, output ready);
endinterface

`default_nettype wire

FILE: hdl/mrr_in_stage.sv
// ----------------------------------------------------------------------------
// mrr_in_stage
// Input register: holds one received byte until the parser consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module mrr_in_stage (
    input  wire        i_clk,
    input  wire        i_rst_n,
    mrr_byte_if.sink   i_rx,
    input  wire        i_take,
    output logic       o_valid,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;

    // A new beat is taken when the register is empty or drains this cycle.
    assign i_rx.ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_byte <= i_rx.rx_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

`default_nettype wire

FILE: hdl/mrr_parser.sv
// ----------------------------------------------------------------------------
// mrr_parser
// Frame state machine, CRC accumulator and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mrr_parser
    import mrr_pkg::*;
#(
    parameter int MAX_PAYLOAD = 252
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_valid,
    input  wire  [7:0]   i_byte,
    output logic         o_take,
    mrr_result_if.source o_res
);

    localparam logic [15:0] MaxLen = 16'(MAX_PAYLOAD);

    t_phase      r_phase, n_phase;
    logic [7:0]  r_addr, n_addr;
    logic [7:0]  r_func, n_func;
    logic [15:0] r_left, n_left;
    logic [7:0]  r_count, n_count;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_crc_lo, n_crc_lo;
    logic [7:0]  r_exc, n_exc;
    logic [2:0]  r_diag, n_diag;
    logic        r_over, n_over;

    logic        r_out_valid;
    t_result     r_res, n_res;
    logic        n_emit;

    logic        w_adv;
    t_fclass     w_class;
    logic [15:0] w_start_len;
    logic [15:0] w_left_dec;
    logic [15:0] w_crc_feed;
    logic [15:0] w_crc_got;
    logic        w_room;

    assign w_adv      = i_valid && (!r_out_valid || o_res.ready);
    assign o_take     = w_adv;
    assign w_class    = func_class(i_byte);
    assign w_left_dec = r_left - 16'd1;
    assign w_crc_feed = crc16_byte(r_crc, i_byte);
    assign w_crc_got  = {i_byte, r_crc_lo};
    assign w_room     = {8'h00, r_count} < MaxLen;

    // Length of a payload that starts after this byte.
    always_comb begin
        unique case (r_phase)
            PH_FUNC:    w_start_len = fixed_len(i_byte);
            PH_FIFO_LO: w_start_len = {r_left[15:8], i_byte};
            default:    w_start_len = {8'h00, i_byte};
        endcase
    end

    // Next phase.
    always_comb begin
        unique case (r_phase)
            PH_FUNC: begin
                unique case (w_class)
                    FC_EXC:   n_phase = PH_EXC;
                    FC_COUNT: n_phase = PH_COUNT;
                    FC_FIFO:  n_phase = PH_FIFO_HI;
                    FC_FIXED: n_phase = (w_start_len != 16'd0) ? PH_PAYLOAD : PH_CRC_LO;
                    default:  n_phase = PH_ADDR;
                endcase
            end
            PH_COUNT, PH_FIFO_LO: begin
                n_phase = (w_start_len != 16'd0) ? PH_PAYLOAD : PH_CRC_LO;
            end
            PH_FIFO_HI: n_phase = PH_FIFO_LO;
            PH_PAYLOAD: n_phase = (w_left_dec == 16'd0) ? PH_CRC_LO : PH_PAYLOAD;
            PH_EXC:     n_phase = PH_CRC_LO;
            PH_CRC_LO:  n_phase = PH_CRC_HI;
            default:    n_phase = (r_phase == PH_FUNC) ? PH_ADDR : PH_FUNC;
        endcase
        if (r_phase == PH_CRC_HI) begin
            n_phase = PH_ADDR;
        end
    end

    // Datapath and result.
    always_comb begin
        n_addr   = r_addr;
        n_func   = r_func;
        n_left   = r_left;
        n_count  = r_count;
        n_crc    = r_crc;
        n_crc_lo = r_crc_lo;
        n_exc    = r_exc;
        n_diag   = r_diag;
        n_over   = r_over;
        n_emit   = 1'b0;
        n_res    = '0;

        unique case (r_phase)
            PH_FUNC: begin
                n_func = i_byte;
                n_crc  = w_crc_feed;
                if (w_class == FC_FIXED) begin
                    n_left = w_start_len;
                    n_over = w_start_len > MaxLen;
                end else if (w_class == FC_UNKNOWN) begin
                    n_emit             = 1'b1;
                    n_res.item_type    = ITEM_STATUS;
                    n_res.frame_status = ST_UNKNOWN;
                end
            end
            PH_COUNT, PH_FIFO_LO: begin
                n_crc  = w_crc_feed;
                n_left = w_start_len;
                n_over = w_start_len > MaxLen;
            end
            PH_FIFO_HI: begin
                n_crc  = w_crc_feed;
                n_left = {i_byte, 8'h00};
            end
            PH_PAYLOAD: begin
                n_crc  = w_crc_feed;
                n_left = w_left_dec;
                if (w_room) begin
                    // The diagnostic echo check looks at the first four bytes only.
                    if (r_func == FN_DIAG) begin
                        if (r_count == 8'd0 && i_byte == 8'h00) n_diag[0] = 1'b1;
                        if (r_count == 8'd1 && i_byte == 8'h00) n_diag[1] = 1'b1;
                        if (r_count == 8'd2 && i_byte != DIAG_ECHO_0) n_diag[2] = 1'b1;
                        if (r_count == 8'd3 && i_byte != DIAG_ECHO_1) n_diag[2] = 1'b1;
                    end
                    n_emit             = 1'b1;
                    n_res.item_type    = ITEM_PAYLOAD;
                    n_res.payload_byte = i_byte;
                    n_res.byte_index   = r_count;
                    n_count            = r_count + 8'd1;
                end
            end
            PH_EXC: begin
                n_crc = w_crc_feed;
                n_exc = i_byte;
            end
            PH_CRC_LO: begin
                n_crc_lo = i_byte;
            end
            PH_CRC_HI: begin
                n_emit               = 1'b1;
                n_res.item_type      = ITEM_STATUS;
                n_res.payload_length = r_count;
                priority if (r_over) begin
                    n_res.frame_status = ST_TOO_LONG;
                end else if (w_crc_got != r_crc) begin
                    n_res.frame_status = ST_CRC_BAD;
                end else if (r_func >= FN_EXC_MIN) begin
                    n_res.frame_status = ST_EXCEPTION;
                end else if (r_func == FN_DIAG && r_diag == DIAG_ALL) begin
                    n_res.frame_status = ST_DIAG_BAD;
                end else begin
                    n_res.frame_status = ST_OK;
                end
                n_res.exception_code = (r_func >= FN_EXC_MIN) ? r_exc : 8'h00;
                n_res.deliver = (n_res.frame_status == ST_OK) && (r_func != FN_DIAG);
            end
            default: begin
                n_crc    = crc16_byte(CRC_INIT, i_byte);
                n_addr   = i_byte;
                n_func   = 8'h00;
                n_left   = 16'd0;
                n_count  = 8'd0;
                n_crc_lo = 8'h00;
                n_exc    = 8'h00;
                n_diag   = 3'b000;
                n_over   = 1'b0;
            end
        endcase

        n_res.slave_address = n_addr;
        n_res.function_code = n_func;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_ADDR;
            r_addr      <= 8'h00;
            r_func      <= 8'h00;
            r_left      <= 16'd0;
            r_count     <= 8'd0;
            r_crc       <= CRC_INIT;
            r_crc_lo    <= 8'h00;
            r_exc       <= 8'h00;
            r_diag      <= 3'b000;
            r_over      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv) begin
                r_phase  <= n_phase;
                r_addr   <= n_addr;
                r_func   <= n_func;
                r_left   <= n_left;
                r_count  <= n_count;
                r_crc    <= n_crc;
                r_crc_lo <= n_crc_lo;
                r_exc    <= n_exc;
                r_diag   <= n_diag;
                r_over   <= n_over;
            end
            if (w_adv) begin
                r_out_valid <= n_emit;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && n_emit) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.item_type      = r_res.item_type;
    assign o_res.slave_address  = r_res.slave_address;
    assign o_res.function_code  = r_res.function_code;
    assign o_res.payload_byte   = r_res.payload_byte;
    assign o_res.byte_index     = r_res.byte_index;
    assign o_res.payload_length = r_res.payload_length;
    assign o_res.frame_status   = r_res.frame_status;
    assign o_res.exception_code = r_res.exception_code;
    assign o_res.deliver        = r_res.deliver;

    a_status_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && n_emit && n_res.item_type == ITEM_STATUS) |=> (r_phase == PH_ADDR))
        else $error("status result did not return the parser to address phase");

    a_payload_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_left != 16'd0))
        else $error("payload phase entered with no bytes left");

    a_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.item_type == ITEM_PAYLOAD) |->
            ({8'h00, r_res.byte_index} < MaxLen && r_res.frame_status == ST_OK))
        else $error("payload result with bad index or status");

    a_deliver_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.deliver) |->
            (r_res.item_type == ITEM_STATUS && r_res.frame_status == ST_OK &&
             r_res.function_code != FN_DIAG))
        else $error("delivered frame is not a clean status");

endmodule

`default_nettype wire

FILE: hdl/modbus_rtu_response_receiver.sv
// Path: a byte taken from i_rx is held in the input register, parsed
// combinationally, and its result is registered before it is offered on o_res.
// Throughput: one byte per cycle unless o_res stalls, set by the single-pass
// parse between the two registers; a byte that causes no result produces no output.
// Reset: synchronous, active low; parser waits for an address, CRC at 0xFFFF.
// ----------------------------------------------------------------------------
// modbus_rtu_response_receiver
// Parses Modbus RTU response frames byte by byte, checks CRC-16/MODBUS and
// emits each payload byte up to MAX_PAYLOAD followed by one end-of-frame status.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_rtu_response_receiver
    import mrr_pkg::*;
#(
    parameter int MAX_PAYLOAD = 252
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    mrr_byte_if.sink     i_rx,
    mrr_result_if.source o_res
);

    logic       w_in_valid;
    logic [7:0] w_in_byte;
    logic       w_take;

    mrr_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_take  (w_take),
        .o_valid (w_in_valid),
        .o_byte  (w_in_byte)
    );

    mrr_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_in_valid),
        .i_byte  (w_in_byte),
        .o_take  (w_take),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire
